// ----- hdl/rfre_pkg.sv -----
`default_nettype none
package rfre_pkg;

  // field widths
  localparam int unsigned ColorW = 8;
  localparam int unsigned LevelW = 7;
  localparam int unsigned TimeW = 16;
  localparam int unsigned AmountW = 8;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIndexW-1:0] RegBaseRed = 3'd0;
  localparam logic [CfgIndexW-1:0] RegBaseGreen = 3'd1;
  localparam logic [CfgIndexW-1:0] RegBaseBlue = 3'd2;
  localparam logic [CfgIndexW-1:0] RegMaxLevel = 3'd3;
  localparam logic [CfgIndexW-1:0] RegRiseTime = 3'd4;
  localparam logic [CfgIndexW-1:0] RegFallTime = 3'd5;

  // item kinds
  localparam logic KindStart = 1'b0;
  localparam logic KindTick = 1'b1;

  // full level in percent
  localparam logic [LevelW-1:0] LevelFull = 7'd100;

  // x / 100 as (x * 5243) >> 19, exact for x below 43690
  localparam int unsigned ProdW = ColorW + LevelW;
  localparam int unsigned RecipW = 13;
  localparam logic [RecipW-1:0] Recip = 13'd5243;
  localparam int unsigned RecipShift = 19;

  // ramp quotient never exceeds the level, so level-width steps suffice
  localparam int unsigned DivSteps = LevelW;
  localparam int unsigned StepCntW = $clog2(DivSteps);

  typedef struct packed {
    logic start;
    logic tick;
    logic mul;
    logic div_step;
    logic level;
    logic scale;
    logic recip;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic rise_busy;
    logic fall_busy;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- hdl/rfre_in_if.sv -----
`default_nettype none
interface rfre_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic [rfre_pkg::AmountW-1:0] tick_amount;

  modport source (output valid, output kind, output tick_amount, input ready);
  modport sink (input valid, input kind, input tick_amount, output ready);
endinterface
`default_nettype wire

// ----- hdl/rfre_out_if.sv -----
`default_nettype none
interface rfre_out_if;
  logic valid;
  logic ready;
  logic [rfre_pkg::ColorW-1:0] red_out;
  logic [rfre_pkg::ColorW-1:0] green_out;
  logic [rfre_pkg::ColorW-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/rfre_ctrl.sv -----
`default_nettype none
module rfre_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_kind,
  output logic                   in_ready,
  input  wire rfre_pkg::status_t status,
  output rfre_pkg::cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_LEVEL = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_RECIP = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  logic [2:0] state, state_next;
  logic [rfre_pkg::StepCntW-1:0] step, step_next;
  logic accept;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    step_next = step;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == rfre_pkg::KindStart) begin
            cmd.start = 1'b1;
            state_next = S_SCALE;
          end else if (status.rise_busy || status.fall_busy) begin
            cmd.tick = 1'b1;
            state_next = S_MUL;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        step_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next = step + 1'b1;
        if (step == rfre_pkg::StepCntW'(rfre_pkg::DivSteps - 1)) begin
          state_next = S_LEVEL;
        end
      end
      S_LEVEL: begin
        cmd.level = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_next = S_RECIP;
      end
      S_RECIP: begin
        cmd.recip = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/rfre_datapath.sv -----
`default_nettype none
module rfre_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                write_en,
  input  wire logic [rfre_pkg::CfgIndexW-1:0]      write_index,
  input  wire logic [rfre_pkg::CfgDataW-1:0]       write_data,
  input  wire logic [rfre_pkg::AmountW-1:0]        tick_amount,
  input  wire rfre_pkg::cmd_t                      cmd,
  output rfre_pkg::status_t                        status,
  rfre_out_if.source                               result
);

  localparam int unsigned NumCh = 3;
  localparam int unsigned MulW = rfre_pkg::LevelW + rfre_pkg::TimeW;
  localparam int unsigned WideW = rfre_pkg::ProdW + rfre_pkg::RecipW;

  // configuration registers
  logic [rfre_pkg::ColorW-1:0] base [NumCh];
  logic [rfre_pkg::LevelW-1:0] max_level;
  logic [rfre_pkg::TimeW-1:0]  rise_time, fall_time;

  // animation state
  logic [rfre_pkg::ColorW-1:0] lat_base [NumCh];
  logic [rfre_pkg::LevelW-1:0] lat_level;
  logic [rfre_pkg::TimeW-1:0]  rise_left, rise_total, fall_left, fall_total;
  logic [rfre_pkg::ColorW-1:0] now [NumCh];
  logic                        is_rise;

  // working registers
  logic [rfre_pkg::TimeW-1:0]  rem;
  logic [rfre_pkg::LevelW-1:0] qbits;
  logic [rfre_pkg::TimeW-1:0]  divisor;
  logic [rfre_pkg::LevelW-1:0] level;
  logic [rfre_pkg::ProdW-1:0]  prod [NumCh];

  // output register
  logic                        out_valid;
  logic [rfre_pkg::ColorW-1:0] out_color [NumCh];

  logic [rfre_pkg::LevelW-1:0] wr_level;
  logic [rfre_pkg::TimeW-1:0]  left_sel, total_sel;
  logic [MulW-1:0]             ramp_prod;
  logic [rfre_pkg::TimeW:0]    trial_src, trial;
  logic [WideW-1:0]            wide [NumCh];

  assign wr_level = (write_data[rfre_pkg::LevelW-1:0] > rfre_pkg::LevelFull)
                    ? rfre_pkg::LevelFull : write_data[rfre_pkg::LevelW-1:0];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumCh; i++) base[i] <= '0;
      max_level <= '0;
      rise_time <= '0;
      fall_time <= '0;
    end else if (write_en) begin
      unique case (write_index)
        rfre_pkg::RegBaseRed:   base[0] <= write_data[rfre_pkg::ColorW-1:0];
        rfre_pkg::RegBaseGreen: base[1] <= write_data[rfre_pkg::ColorW-1:0];
        rfre_pkg::RegBaseBlue:  base[2] <= write_data[rfre_pkg::ColorW-1:0];
        rfre_pkg::RegMaxLevel:  max_level <= wr_level;
        rfre_pkg::RegRiseTime:  rise_time <= write_data;
        rfre_pkg::RegFallTime:  fall_time <= write_data;
        default: ;
      endcase
    end
  end

  assign status.rise_busy = (rise_left != '0);
  assign status.fall_busy = (fall_left != '0);
  assign status.out_free = !out_valid || result.ready;

  // ramp operands of the active phase
  assign left_sel = is_rise ? rise_left : fall_left;
  assign total_sel = is_rise ? rise_total : fall_total;
  assign ramp_prod = MulW'(lat_level) * MulW'(left_sel);

  // restoring division step
  assign trial_src = {rem, qbits[rfre_pkg::LevelW-1]};
  assign trial = trial_src - {1'b0, divisor};

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      wide[i] = WideW'(prod[i]) * WideW'(rfre_pkg::Recip);
    end
  end

  // animation state and countdowns
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumCh; i++) begin
        lat_base[i] <= '0;
        now[i] <= '0;
      end
      lat_level <= '0;
      rise_left <= '0;
      rise_total <= '0;
      fall_left <= '0;
      fall_total <= '0;
      is_rise <= 1'b0;
    end else begin
      if (cmd.start) begin
        for (int i = 0; i < NumCh; i++) lat_base[i] <= base[i];
        lat_level <= max_level;
        rise_left <= rise_time;
        rise_total <= rise_time;
        fall_left <= fall_time;
        fall_total <= fall_time;
      end
      if (cmd.tick) begin
        is_rise <= status.rise_busy;
        if (status.rise_busy) begin
          rise_left <= (rise_left > rfre_pkg::TimeW'(tick_amount))
                       ? rise_left - rfre_pkg::TimeW'(tick_amount) : '0;
        end else begin
          fall_left <= (fall_left > rfre_pkg::TimeW'(tick_amount))
                       ? fall_left - rfre_pkg::TimeW'(tick_amount) : '0;
        end
      end
      if (cmd.recip) begin
        for (int i = 0; i < NumCh; i++) begin
          now[i] <= wide[i][rfre_pkg::RecipShift +: rfre_pkg::ColorW];
        end
      end
    end
  end

  // ramp level arithmetic
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      level <= (rise_time == '0) ? max_level : '0;
    end else if (cmd.level) begin
      level <= is_rise ? lat_level - qbits : qbits;
    end
    if (cmd.mul) begin
      rem <= ramp_prod[MulW-1 -: rfre_pkg::TimeW];
      qbits <= ramp_prod[rfre_pkg::LevelW-1:0];
      divisor <= total_sel;
    end else if (cmd.div_step) begin
      rem <= trial[rfre_pkg::TimeW] ? trial_src[rfre_pkg::TimeW-1:0]
                                    : trial[rfre_pkg::TimeW-1:0];
      qbits <= {qbits[rfre_pkg::LevelW-2:0], ~trial[rfre_pkg::TimeW]};
    end
    if (cmd.scale) begin
      for (int i = 0; i < NumCh; i++) begin
        prod[i] <= rfre_pkg::ProdW'(lat_base[i]) * rfre_pkg::ProdW'(level);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int i = 0; i < NumCh; i++) out_color[i] <= now[i];
    end
  end

  assign result.valid = out_valid;
  assign result.red_out = out_color[0];
  assign result.green_out = out_color[1];
  assign result.blue_out = out_color[2];

endmodule
`default_nettype wire

// ----- hdl/rgb_fade_ramp_engine.sv -----
// LED fade engine: ramps a base colour up to a peak level and back down.
// Configuration: write_en, write_index, write_data; a write lands at the
// clock edge where write_en is high; indexes 0..5 are red, green, blue,
// peak level (low 7 bits; above 100 stored as 100), rise time and fall time.
// Writes take effect at the next start transaction only.
// Input channel feed: kind 0 starts an animation, kind 1 is a time tick
// carrying tick_amount elapsed units. Output channel result: one colour
// transaction (red_out, green_out, blue_out) for every input transaction.
// A start passes through the scale, reciprocal and output states; a tick
// during a ramp first passes through the multiply, divide and level states;
// a tick with both ramps finished goes straight to the output state. A ramp
// tick forms its ramp level in the bit-serial divider; feed.ready rises as
// the result is loaded into the output register.
// A stalled receiver holds the output register; a finished result waits in
// the controller until the register is free, and feed.ready stays low.
// Synchronous reset clears configuration, ramps and colours to zero.
`default_nettype none
module rgb_fade_ramp_engine (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           write_en,
  input  wire logic [rfre_pkg::CfgIndexW-1:0] write_index,
  input  wire logic [rfre_pkg::CfgDataW-1:0]  write_data,
  rfre_in_if.sink                             feed,
  rfre_out_if.source                          result
);

  rfre_pkg::cmd_t    cmd;
  rfre_pkg::status_t status;
  logic              ready;

  assign feed.ready = ready;

  // sequencer
  rfre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (feed.valid),
    .in_kind  (feed.kind),
    .in_ready (ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and state
  rfre_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .tick_amount (feed.tick_amount),
    .cmd         (cmd),
    .status      (status),
    .result      (result)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb_rgb_fade_ramp_engine.sv -----
`default_nettype none
module tb_rgb_fade_ramp_engine;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned TargetItems = 450;

  typedef struct packed {
    logic [rfre_pkg::ColorW-1:0] red;
    logic [rfre_pkg::ColorW-1:0] green;
    logic [rfre_pkg::ColorW-1:0] blue;
  } colour_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_en = 1'b0;
  logic [rfre_pkg::CfgIndexW-1:0] write_index = '0;
  logic [rfre_pkg::CfgDataW-1:0] write_data = '0;

  rfre_in_if feed_ch ();
  rfre_out_if result_ch ();

  rgb_fade_ramp_engine dut (
    .clk(clk),
    .rst(rst),
    .write_en(write_en),
    .write_index(write_index),
    .write_data(write_data),
    .feed(feed_ch),
    .result(result_ch)
  );

  // fade state as the block should hold it
  logic [rfre_pkg::ColorW-1:0] reg_red = '0, reg_green = '0, reg_blue = '0;
  logic [rfre_pkg::LevelW-1:0] reg_level = '0;
  logic [rfre_pkg::TimeW-1:0] reg_rise = '0, reg_fall = '0;
  int unsigned lat_red = 0, lat_green = 0, lat_blue = 0, lat_level = 0;
  int unsigned rise_left = 0, rise_total = 0, fall_left = 0, fall_total = 0;
  colour_t shown = '0;
  colour_t colours_due[$];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  int unsigned rx_stall = 0;
  int unsigned results_seen = 0;
  int unsigned results_drawn = 0;
  int unsigned hold_len = 0;
  bit hold_out = 1'b0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // latched base colour scaled by a level in percent
  function automatic colour_t scale_colour(input int unsigned level);
    colour_t c;
    c.red = rfre_pkg::ColorW'(lat_red * level / rfre_pkg::LevelFull);
    c.green = rfre_pkg::ColorW'(lat_green * level / rfre_pkg::LevelFull);
    c.blue = rfre_pkg::ColorW'(lat_blue * level / rfre_pkg::LevelFull);
    return c;
  endfunction

  // advance the fade by one accepted transaction and queue the colour due
  task automatic advance_fade(input logic kind,
                              input logic [rfre_pkg::AmountW-1:0] amount);
    int unsigned level;
    if (kind == rfre_pkg::KindStart) begin
      lat_red = reg_red;
      lat_green = reg_green;
      lat_blue = reg_blue;
      lat_level = reg_level;
      shown = scale_colour(reg_rise == 0 ? lat_level : 0);
      rise_left = reg_rise;
      rise_total = reg_rise;
      fall_left = reg_fall;
      fall_total = reg_fall;
    end else if (rise_left != 0) begin
      rise_left = (rise_left > amount) ? rise_left - amount : 0;
      level = lat_level;
      if (rise_total != 0) level = lat_level - lat_level * rise_left / rise_total;
      shown = scale_colour(level);
    end else if (fall_left != 0) begin
      fall_left = (fall_left > amount) ? fall_left - amount : 0;
      level = lat_level;
      if (fall_total != 0) level = lat_level * fall_left / fall_total;
      shown = scale_colour(level);
    end
    colours_due.push_back(shown);
  endtask

  // register write, mirrored into the expected configuration
  task automatic write_reg(input logic [rfre_pkg::CfgIndexW-1:0] idx,
                           input logic [rfre_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    write_en = 1'b1;
    write_index = idx;
    write_data = data;
    @(posedge clk);
    case (idx)
      rfre_pkg::RegBaseRed: reg_red = data[rfre_pkg::ColorW-1:0];
      rfre_pkg::RegBaseGreen: reg_green = data[rfre_pkg::ColorW-1:0];
      rfre_pkg::RegBaseBlue: reg_blue = data[rfre_pkg::ColorW-1:0];
      rfre_pkg::RegMaxLevel:
        reg_level = (data[rfre_pkg::LevelW-1:0] > rfre_pkg::LevelFull)
                    ? rfre_pkg::LevelFull : data[rfre_pkg::LevelW-1:0];
      rfre_pkg::RegRiseTime: reg_rise = data;
      rfre_pkg::RegFallTime: reg_fall = data;
      default: ;
    endcase
    @(negedge clk);
    write_en = 1'b0;
  endtask

  // one input transaction with an optional idle gap ahead of it
  task automatic send_item(input logic kind,
                           input logic [rfre_pkg::AmountW-1:0] amount);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap != 0) begin
      feed_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    feed_ch.valid = 1'b1;
    feed_ch.kind = kind;
    feed_ch.tick_amount = amount;
    do @(posedge clk); while (!feed_ch.ready);
    items_sent++;
    advance_fade(kind, amount);
  endtask

  // stop offering and wait until every colour due has come back
  task automatic settle_block();
    @(negedge clk);
    feed_ch.valid = 1'b0;
    while (colours_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // receiver ready: random stalls and the long hold-off
  always @(negedge clk) begin
    if (results_drawn != results_seen) begin
      results_drawn = results_seen;
      rx_stall = rx_idle ? $urandom_range(0, 15) : 0;
    end
    if (hold_out) begin
      result_ch.ready = 1'b0;
    end else if (rx_stall != 0) begin
      result_ch.ready = 1'b0;
      rx_stall--;
    end else begin
      result_ch.ready = 1'b1;
    end
  end

  initial begin
    forever begin
      wait (hold_len != 0);
      hold_out = 1'b1;
      repeat (hold_len) @(posedge clk);
      hold_out = 1'b0;
      wait (hold_len == 0);
    end
  end

  // compare each result transaction with the oldest colour due
  always @(posedge clk) begin : check_result
    colour_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (colours_due.size() == 0) begin
        $error("result transaction with no colour due");
        mismatches++;
      end else begin
        want = colours_due.pop_front();
        if (result_ch.red_out !== want.red) begin
          $error("red_out: expected %0d, got %0d", want.red, result_ch.red_out);
          mismatches++;
        end
        if (result_ch.green_out !== want.green) begin
          $error("green_out: expected %0d, got %0d", want.green, result_ch.green_out);
          mismatches++;
        end
        if (result_ch.blue_out !== want.blue) begin
          $error("blue_out: expected %0d, got %0d", want.blue, result_ch.blue_out);
          mismatches++;
        end
      end
      results_seen++;
    end
  end

  // ticks before any start show the reset colour
  task automatic test_tick_before_start();
    send_item(rfre_pkg::KindTick, 8'hFF);
    send_item(rfre_pkg::KindTick, 8'h00);
    settle_block();
  endtask

  // zero rise time jumps straight to the peak level, upper data bits dropped
  task automatic test_instant_colour();
    write_reg(rfre_pkg::RegBaseRed, 16'hFFFF);
    write_reg(rfre_pkg::RegBaseGreen, 16'hAB80);
    write_reg(rfre_pkg::RegBaseBlue, 16'h0001);
    write_reg(rfre_pkg::RegMaxLevel, 16'h007F);
    write_reg(rfre_pkg::RegRiseTime, 16'h0000);
    write_reg(rfre_pkg::RegFallTime, 16'h0000);
    send_item(rfre_pkg::KindStart, 8'hA5);
    send_item(rfre_pkg::KindTick, 8'hFF);
    settle_block();
    write_reg(rfre_pkg::RegMaxLevel, 16'h0065);
    send_item(rfre_pkg::KindStart, 8'h5A);
    settle_block();
    write_reg(rfre_pkg::RegMaxLevel, 16'h0000);
    send_item(rfre_pkg::KindStart, 8'h00);
    settle_block();
  endtask

  // full rise then full fall, floor at zero, then held colour
  task automatic test_ramp_up_down();
    write_reg(rfre_pkg::RegBaseRed, 16'h55C8);
    write_reg(rfre_pkg::RegBaseGreen, 16'h0064);
    write_reg(rfre_pkg::RegBaseBlue, 16'hFF32);
    write_reg(rfre_pkg::RegMaxLevel, 16'hFF49);
    write_reg(rfre_pkg::RegRiseTime, 16'd10);
    write_reg(rfre_pkg::RegFallTime, 16'd300);
    send_item(rfre_pkg::KindStart, 8'h00);
    send_item(rfre_pkg::KindTick, 8'd3);
    send_item(rfre_pkg::KindTick, 8'd0);
    send_item(rfre_pkg::KindTick, 8'd7);
    send_item(rfre_pkg::KindTick, 8'd255);
    send_item(rfre_pkg::KindTick, 8'd44);
    send_item(rfre_pkg::KindTick, 8'd1);
    send_item(rfre_pkg::KindTick, 8'd200);
    settle_block();
  endtask

  // writes during a ramp wait for the next start; unused indexes ignored
  task automatic test_late_writes();
    write_reg(rfre_pkg::RegBaseRed, 16'd90);
    write_reg(rfre_pkg::RegBaseGreen, 16'd180);
    write_reg(rfre_pkg::RegBaseBlue, 16'd255);
    write_reg(rfre_pkg::RegMaxLevel, 16'd100);
    write_reg(rfre_pkg::RegRiseTime, 16'd1000);
    write_reg(rfre_pkg::RegFallTime, 16'd0);
    send_item(rfre_pkg::KindStart, 8'h00);
    send_item(rfre_pkg::KindTick, 8'd128);
    settle_block();
    write_reg(rfre_pkg::RegBaseRed, 16'd17);
    write_reg(rfre_pkg::RegBaseGreen, 16'd250);
    write_reg(rfre_pkg::RegBaseBlue, 16'd3);
    write_reg(rfre_pkg::RegMaxLevel, 16'd55);
    write_reg(rfre_pkg::RegRiseTime, 16'd0);
    write_reg(rfre_pkg::RegFallTime, 16'd65535);
    write_reg(rfre_pkg::RegFallTime + 3'd1, 16'hFFFF);
    write_reg(rfre_pkg::RegFallTime + 3'd2, 16'h1234);
    send_item(rfre_pkg::KindTick, 8'd64);
    send_item(rfre_pkg::KindTick, 8'd255);
    send_item(rfre_pkg::KindStart, 8'hFF);
    send_item(rfre_pkg::KindTick, 8'd255);
    send_item(rfre_pkg::KindTick, 8'd1);
    settle_block();
  endtask

  // receiver holds off while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    tx_idle = 1'b0;
    hold_len = 400;
    send_item(rfre_pkg::KindStart, 8'h00);
    repeat (15) send_item(rfre_pkg::KindTick, 8'($urandom));
    settle_block();
    hold_len = 0;
    tx_idle = 1'b1;
  endtask

  // random ramp time, mostly short so that both ramps finish
  function automatic logic [rfre_pkg::TimeW-1:0] pick_time();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return rfre_pkg::TimeW'($urandom_range(1, 20));
      4, 5, 6, 7: return rfre_pkg::TimeW'($urandom_range(21, 800));
      default: return rfre_pkg::TimeW'($urandom_range(801, 4000));
    endcase
  endfunction

  // random configurations, most followed by a start, each by a run of ticks
  task automatic test_random_fades();
    int unsigned n_ticks;
    logic [rfre_pkg::CfgDataW-1:0] level_data;
    while (items_sent < TargetItems) begin
      settle_block();
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
        0: level_data = '0;
        1: level_data = rfre_pkg::CfgDataW'(rfre_pkg::LevelFull);
        2: level_data = {rfre_pkg::CfgDataW'($urandom) & 16'hFF80}
                        | 16'($urandom_range(101, 127));
        default: level_data = 16'($urandom);
      endcase
      write_reg(rfre_pkg::RegBaseRed, 16'($urandom));
      write_reg(rfre_pkg::RegBaseGreen, 16'($urandom));
      write_reg(rfre_pkg::RegBaseBlue, 16'($urandom));
      write_reg(rfre_pkg::RegMaxLevel, level_data);
      write_reg(rfre_pkg::RegRiseTime, pick_time());
      write_reg(rfre_pkg::RegFallTime, pick_time());
      if ($urandom_range(0, 4) == 0)
        write_reg(3'(rfre_pkg::RegFallTime + 1 + $urandom_range(0, 1)), 16'($urandom));
      // now and then carry on the previous fade without a start
      if ($urandom_range(0, 7) != 0) send_item(rfre_pkg::KindStart, 8'($urandom));
      n_ticks = $urandom_range(4, 24);
      repeat (n_ticks) begin
        if ($urandom_range(0, 19) == 0)
          send_item(rfre_pkg::KindStart, 8'($urandom));
        else if ($urandom_range(0, 3) == 0)
          send_item(rfre_pkg::KindTick, 8'($urandom_range(0, 15)));
        else
          send_item(rfre_pkg::KindTick, 8'($urandom));
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    feed_ch.valid = 1'b0;
    feed_ch.kind = rfre_pkg::KindStart;
    feed_ch.tick_amount = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_tick_before_start();
    test_instant_colour();
    test_ramp_up_down();
    test_late_writes();
    test_backpressure();
    test_random_fades();

    settle_block();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && colours_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
